// ----- rtl/core/fss_pkg.sv -----
package fss_pkg;

   localparam int unsigned SCORE_W = 11;
   localparam int unsigned QLEN_W  = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LEN  = 2'd2;

   localparam int SCORE_MIN = -1024;
   localparam int SCORE_MAX = 1023;

   localparam int BONUS_START    = 50;
   localparam int BONUS_PREFIX   = 10;
   localparam int BONUS_BOUNDARY = 30;
   localparam int BONUS_CONSEC   = 20;
   localparam int MISS_PENALTY   = -1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;

   typedef struct packed {
      logic                      too_long;
      logic signed [SCORE_W-1:0] score;
      logic                      found;
      logic                      end_of_target;
      logic [7:0]                position;
      logic                      match_here;
   } rsp_type;

   function automatic logic is_upper(input logic [7:0] c);
      is_upper = (c >= 8'h41) && (c <= 8'h5a);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      is_lower = (c >= 8'h61) && (c <= 8'h7a);
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      fold_case = is_upper(c) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      is_separator = (c == CH_SPACE) || (c == CH_UNDER) || (c == CH_DASH) ||
                     (c == CH_DOT) || (c == CH_SLASH);
   endfunction

endpackage

// ----- rtl/core/fuzzy_subsequence_scorer_top.sv -----
// Fuzzy subsequence scorer: streams one target string, one character per item, against a
// query of up to MAX_QUERY_LEN characters (case-insensitive for ASCII letters) and returns
// one result per item. The final item of a target (req_tlast) carries found, score and
// too_long. The block takes one item every cycle while req_tready is high: all matching
// and scoring for a character is one register-to-register pass, and a two-entry output
// buffer catches one result in its skid entry on a stall, holding req_tready low until it drains.
// Query registers must be written through the csr_ port between targets; nothing enforces it.
module fuzzy_subsequence_scorer_top #(
   parameter int unsigned MAX_QUERY_LEN  = 16,
   parameter int unsigned MAX_TARGET_LEN = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] target_char
   input  logic                               req_tuser,   // [0] no_char
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // [0] match_here, [8:1] position,
                                                           // [9] found, [20:10] score,
                                                           // [21] too_long, [23:22] zero
   output logic                               rsp_tlast,
   input  logic                               csr_wr_en,
   input  logic [fss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fss_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import fss_pkg::*;

   logic [63:0]        query_low_ff, query_low_in;
   logic [63:0]        query_high_ff, query_high_in;
   logic [QLEN_W-1:0]  query_len_ff, query_len_in;
   logic               accept;
   rsp_type            core_rsp, out_rsp;

   always_comb begin
      query_low_in  = query_low_ff;
      query_high_in = query_high_ff;
      query_len_in  = query_len_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_QUERY_LOW:  query_low_in  = csr_wr_data;
            CSR_QUERY_HIGH: query_high_in = csr_wr_data;
            CSR_QUERY_LEN:  query_len_in  = csr_wr_data[QLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_low_ff  <= '0;
         query_high_ff <= '0;
         query_len_ff  <= '0;
      end else begin
         query_low_ff  <= query_low_in;
         query_high_ff <= query_high_in;
         query_len_ff  <= query_len_in;
      end
   end

   assign accept = req_tvalid && req_tready;

   fss_score_core #(
      .MAX_QUERY_LEN  (MAX_QUERY_LEN),
      .MAX_TARGET_LEN (MAX_TARGET_LEN)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .target_char    (req_tdata),
      .no_char        (req_tuser),
      .last_of_target (req_tlast),
      .query_low      (query_low_ff),
      .query_high     (query_high_ff),
      .query_length   (query_len_ff),
      .result         (core_rsp)
   );

   fss_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {2'b00, out_rsp.too_long, out_rsp.score, out_rsp.found,
                       out_rsp.position, out_rsp.match_here};
   assign rsp_tlast = out_rsp.end_of_target;

endmodule

// ----- rtl/core/fss_score_core.sv -----
module fss_score_core #(
   parameter int unsigned MAX_QUERY_LEN  = 16,
   parameter int unsigned MAX_TARGET_LEN = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    target_char,
   input  logic                          no_char,
   input  logic                          last_of_target,
   input  logic [63:0]                   query_low,
   input  logic [63:0]                   query_high,
   input  logic [fss_pkg::QLEN_W-1:0]    query_length,
   output fss_pkg::rsp_type              result
);
   import fss_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_TARGET_LEN + 1);
   localparam int unsigned SUM_W = IDX_W + 4;
   localparam logic [QLEN_W-1:0] MAXQ = QLEN_W'(MAX_QUERY_LEN);
   localparam logic [IDX_W-1:0] MAXT = IDX_W'(MAX_TARGET_LEN);
   localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(SCORE_MIN);
   localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(SCORE_MAX);

   logic [QLEN_W-1:0]          query_pos_ff, query_pos_in;
   logic [IDX_W-1:0]           char_index_ff, char_index_in;
   logic [7:0]                 prev_char_ff, prev_char_in;
   logic                       prev_match_ff, prev_match_in;
   logic                       any_match_ff, any_match_in;
   logic signed [SCORE_W-1:0]  score_ff, score_in;
   logic                       overflow_ff, overflow_in;

   logic [QLEN_W-1:0]          act_len;
   logic [7:0]                 q_char;
   logic                       char_ok, active, hit, at_start, boundary;
   logic [IDX_W+1:0]           triple;
   logic signed [SUM_W-1:0]    delta, sum, sat;
   logic [QLEN_W-1:0]          qpos_upd;
   logic signed [SCORE_W-1:0]  score_upd;
   logic                       ovf_upd, fnd;

   assign act_len  = (query_length > MAXQ) ? MAXQ : query_length;
   assign q_char   = query_pos_ff[3] ? query_high[{query_pos_ff[2:0], 3'b000} +: 8]
                                     : query_low[{query_pos_ff[2:0], 3'b000} +: 8];
   assign char_ok  = !no_char && (char_index_ff < MAXT);
   assign active   = char_ok && (query_pos_ff < act_len);
   assign hit      = active && (fold_case(q_char) == fold_case(target_char));
   assign at_start = (char_index_ff == '0);
   assign boundary = is_separator(prev_char_ff) ||
                     (is_lower(prev_char_ff) && is_upper(target_char));
   assign triple   = {1'b0, char_index_ff, 1'b0} + {2'b00, char_index_ff};

   always_comb begin
      delta = '0;
      if (hit) begin
         if (at_start) begin
            delta = SUM_W'(BONUS_START);
         end else if (boundary) begin
            delta = SUM_W'(BONUS_BOUNDARY);
         end
         if (prev_match_ff) begin
            delta = delta + SUM_W'(BONUS_CONSEC);
         end else if (!any_match_ff && !at_start) begin
            delta = delta - $signed({2'b00, triple});
         end
         if (at_start && (query_pos_ff == '0)) begin
            delta = delta + SUM_W'(BONUS_PREFIX);
         end
      end else if (active && any_match_ff) begin
         delta = SUM_W'(MISS_PENALTY);
      end
      sum = SUM_W'(score_ff) + delta;
      if (sum < S_MIN) begin
         sat = S_MIN;
      end else if (sum > S_MAX) begin
         sat = S_MAX;
      end else begin
         sat = sum;
      end
   end

   assign score_upd = SCORE_W'(sat);
   assign qpos_upd  = hit ? query_pos_ff + 1'b1 : query_pos_ff;
   assign ovf_upd   = overflow_ff || (!no_char && (char_index_ff >= MAXT));
   assign fnd       = !ovf_upd && (qpos_upd >= act_len);

   always_comb begin
      result.match_here    = hit;
      result.position      = 8'(char_index_ff);
      result.end_of_target = last_of_target;
      result.found         = last_of_target && fnd;
      result.score         = (last_of_target && fnd) ? score_upd : '0;
      result.too_long      = last_of_target && ovf_upd;
   end

   always_comb begin
      query_pos_in  = query_pos_ff;
      char_index_in = char_index_ff;
      prev_char_in  = prev_char_ff;
      prev_match_in = prev_match_ff;
      any_match_in  = any_match_ff;
      score_in      = score_ff;
      overflow_in   = overflow_ff;
      if (accept) begin
         if (last_of_target) begin
            query_pos_in  = '0;
            char_index_in = '0;
            prev_char_in  = '0;
            prev_match_in = 1'b0;
            any_match_in  = 1'b0;
            score_in      = '0;
            overflow_in   = 1'b0;
         end else begin
            overflow_in  = ovf_upd;
            query_pos_in = qpos_upd;
            if (active) begin
               score_in      = score_upd;
               prev_match_in = hit;
               any_match_in  = any_match_ff || hit;
            end
            if (char_ok) begin
               prev_char_in  = target_char;
               char_index_in = char_index_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_pos_ff  <= '0;
         char_index_ff <= '0;
         prev_char_ff  <= '0;
         prev_match_ff <= 1'b0;
         any_match_ff  <= 1'b0;
         score_ff      <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         query_pos_ff  <= query_pos_in;
         char_index_ff <= char_index_in;
         prev_char_ff  <= prev_char_in;
         prev_match_ff <= prev_match_in;
         any_match_ff  <= any_match_in;
         score_ff      <= score_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

// ----- rtl/core/fss_out_buf.sv -----
module fss_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  fss_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output fss_pkg::rsp_type out_data
);
   import fss_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take      = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            main_data_in = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
